[rtl/core/depthwise_conv2d_int8_same_pad_macros.svh]
// Assertion macros shared by the depthwise convolution RTL.
// Each macro takes a label, the clock, the active-low reset, the two sides of
// the implication and the message text.
`ifndef DEPTHWISE_CONV2D_INT8_SAME_PAD_MACROS_SVH
`define DEPTHWISE_CONV2D_INT8_SAME_PAD_MACROS_SVH

// Same-cycle implication.
`define DWC_ASSERT_IMP(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DWC_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/dwc_pkg.sv]
`timescale 1ns / 1ps

package dwc_pkg;

    // Default sizes of the stores.
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_KERNEL = 7;

    // Field widths.
    localparam int SAMPLE_W    = 8;
    localparam int BIAS_W      = 32;
    localparam int ACC_W       = 32;
    localparam int PROD_W      = 2 * SAMPLE_W;
    localparam int OUT_COORD_W = 6;
    localparam int MODE_W      = 2;

    // Stream bus widths.
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = MODE_W;
    localparam int M_TDATA_W = 48;

    // Configuration port.
    localparam int CFG_W     = 7;
    localparam int CFG_K_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0]   CFG_H_RESET = 7'd64;
    localparam logic [CFG_W-1:0]   CFG_W_RESET = 7'd64;
    localparam logic [CFG_K_W-1:0] CFG_K_RESET = 3'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEIGHT = 2'd0,
        CFG_WIDTH  = 2'd1,
        CFG_KERNEL = 2'd2
    } cfg_idx_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_WEIGHT = 2'd0,
        MODE_BIAS   = 2'd1,
        MODE_PIXEL  = 2'd2,
        MODE_DRAIN  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_MAC,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic load;   // preload the accumulator with the bias
        logic issue;  // a tap read issued this cycle contributes to the sum
    } mac_ctl_t;

endpackage

[rtl/core/dwc_ram.sv]
`timescale 1ns / 1ps

module dwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/dwc_mac.sv]
`timescale 1ns / 1ps

module dwc_mac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dwc_pkg::mac_ctl_t            ctl,
    input  logic [dwc_pkg::BIAS_W-1:0]   bias,
    input  logic [dwc_pkg::SAMPLE_W-1:0] tap,
    input  logic [dwc_pkg::SAMPLE_W-1:0] pix,
    output logic [dwc_pkg::ACC_W-1:0]    acc
);

    import dwc_pkg::*;

    logic                     issue_d1_reg;
    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;

    // The product of the two store words read in the previous cycle.
    assign prod_next = $signed(tap) * $signed(pix);

    // Accumulate with wraparound at the accumulator width.
    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = ACC_W'(bias);
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Valid flags follow the store read latency and the product register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_d1_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            issue_d1_reg   <= ctl.issue;
            prod_valid_reg <= issue_d1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[rtl/core/depthwise_conv2d_int8_same_pad.sv]
// Load items (weight, bias, pixel) are accepted back to back unless a configuration write
// holds the input. A drain runs setup, a shared multiply-accumulate step per tap, flush
// and done; the input waits until its result is registered at the output, which waits
// out a stall. A drain flagged dirty by a configuration write first divides its position,
// if in range, by the width bit-serially, one step per address bit (12 at default sizes).
// Reset clears the control state, not the stores, and loads the registers with 64, 64, 3.
`timescale 1ns / 1ps
`include "depthwise_conv2d_int8_same_pad_macros.svh"

module depthwise_conv2d_int8_same_pad #(
    parameter int MAX_HEIGHT = dwc_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_WIDTH  = dwc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_KERNEL = dwc_pkg::DEF_MAX_KERNEL
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic [dwc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dwc_pkg::CFG_W-1:0]     cfg_data,
    // Input stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dwc_pkg::S_TDATA_W-1:0] s_tdata,  // sample[7:0], bias_value[39:8]
    input  logic [dwc_pkg::S_TUSER_W-1:0] s_tuser,  // mode[1:0]
    // Output stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dwc_pkg::M_TDATA_W-1:0] m_tdata,  // result[31:0], out_row[37:32],
                                                    // out_col[43:38], zeros[47:44]
    output logic                          m_tlast   // last_of_channel
);

    import dwc_pkg::*;

    localparam int IMG_DEPTH = MAX_HEIGHT * MAX_WIDTH;
    localparam int TAP_DEPTH = MAX_KERNEL * MAX_KERNEL;
    localparam int PIX_AW    = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int PIX_CW    = $clog2(IMG_DEPTH + 1);
    localparam int TAP_AW    = (TAP_DEPTH > 1) ? $clog2(TAP_DEPTH) : 1;
    localparam int TAP_CW    = $clog2(TAP_DEPTH + 1);
    localparam int H_W       = $clog2(MAX_HEIGHT + 1);
    localparam int W_W       = $clog2(MAX_WIDTH + 1);
    localparam int K_W       = $clog2(MAX_KERNEL + 1);
    localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int KC_W      = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int PW_W      = K_W + W_W;
    localparam int DC_W      = (PIX_AW > 1) ? $clog2(PIX_AW) : 1;
    localparam int MAX_DIM   = (MAX_HEIGHT > MAX_WIDTH) ? MAX_HEIGHT : MAX_WIDTH;
    localparam int CO_W      = $clog2(MAX_DIM + MAX_KERNEL + 1) + 1;
    localparam int PA_W      = $clog2(IMG_DEPTH + 2 * MAX_KERNEL * MAX_WIDTH
                                      + 2 * MAX_KERNEL + 1) + 1;

    // Configuration registers and the sizes derived from them.
    logic [CFG_W-1:0]   cfg_h_reg;
    logic [CFG_W-1:0]   cfg_w_reg;
    logic [CFG_K_W-1:0] cfg_k_reg;
    logic               cfg_wait_reg;
    logic [H_W-1:0]     h_eff;
    logic [W_W-1:0]     w_eff;
    logic [K_W-1:0]     k_eff;
    logic [K_W-1:0]     pad_eff;
    logic [KC_W-1:0]    k_m1;
    logic [PIX_CW-1:0]  npix_reg;
    logic [TAP_CW-1:0]  kk_reg;
    logic [PW_W-1:0]    padw_reg;

    // Sequencer state.
    state_t             state_reg;
    state_t             state_next;
    logic               dirty_reg;
    logic               dirty_next;
    logic [BIAS_W-1:0]  bias_reg;
    logic [BIAS_W-1:0]  bias_next;
    logic [TAP_CW-1:0]  tap_pos_reg;
    logic [TAP_CW-1:0]  tap_pos_next;
    logic [PIX_CW-1:0]  pix_pos_reg;
    logic [PIX_CW-1:0]  pix_pos_next;
    logic [PIX_AW-1:0]  drain_pos_reg;
    logic [PIX_AW-1:0]  drain_pos_next;
    logic [ROW_W-1:0]   row_reg;
    logic [ROW_W-1:0]   row_next;
    logic [COL_W-1:0]   col_reg;
    logic [COL_W-1:0]   col_next;

    // Division of the drain position by the width.
    logic [PIX_AW-1:0]  div_q_reg;
    logic [PIX_AW-1:0]  div_q_next;
    logic [W_W-1:0]     rem_reg;
    logic [W_W-1:0]     rem_next;
    logic [DC_W-1:0]    div_cnt_reg;
    logic [DC_W-1:0]    div_cnt_next;
    logic [W_W:0]       div_shift;
    logic               div_ge;

    // Tap walk.
    logic [KC_W-1:0]        kh_reg;
    logic [KC_W-1:0]        kh_next;
    logic [KC_W-1:0]        kw_reg;
    logic [KC_W-1:0]        kw_next;
    logic [TAP_AW-1:0]      taddr_reg;
    logic [TAP_AW-1:0]      taddr_next;
    logic signed [CO_W-1:0] ih_reg;
    logic signed [CO_W-1:0] ih_next;
    logic signed [CO_W-1:0] iw_reg;
    logic signed [CO_W-1:0] iw_next;
    logic signed [CO_W-1:0] iw0_reg;
    logic signed [CO_W-1:0] iw0_next;
    logic signed [PA_W-1:0] paddr_reg;
    logic signed [PA_W-1:0] paddr_next;
    logic signed [PA_W-1:0] rowbase_reg;
    logic signed [PA_W-1:0] rowbase_next;
    logic signed [CO_W-1:0] h_s;
    logic signed [CO_W-1:0] w_s;
    logic signed [PA_W-1:0] pa_start;
    logic                   in_image;
    logic                   last_tap;
    logic                   flush_reg;
    logic                   flush_next;

    // Output register.
    logic                    m_tvalid_reg;
    logic                    m_tvalid_next;
    logic [ACC_W-1:0]        result_reg;
    logic [ACC_W-1:0]        result_next;
    logic [OUT_COORD_W-1:0]  out_row_reg;
    logic [OUT_COORD_W-1:0]  out_row_next;
    logic [OUT_COORD_W-1:0]  out_col_reg;
    logic [OUT_COORD_W-1:0]  out_col_next;
    logic                    out_last_reg;
    logic                    out_last_next;
    logic                    out_free;
    logic [PIX_CW-1:0]       drain_inc;
    logic                    drain_last;

    // Input decode and store ports.
    logic                accept;
    mode_t               in_mode;
    logic [SAMPLE_W-1:0] in_sample;
    logic [BIAS_W-1:0]   in_bias;
    logic                drain_wrap;
    logic                tap_we;
    logic                pix_we;
    logic [PIX_AW-1:0]   pix_raddr;
    logic [SAMPLE_W-1:0] tap_rdata;
    logic [SAMPLE_W-1:0] pix_rdata;
    mac_ctl_t            mac_ctl;
    logic [ACC_W-1:0]    acc;

    assign accept    = s_tvalid && s_tready;
    assign in_mode   = mode_t'(s_tuser);
    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_bias   = s_tdata[SAMPLE_W +: BIAS_W];

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_h_reg    <= CFG_H_RESET;
            cfg_w_reg    <= CFG_W_RESET;
            cfg_k_reg    <= CFG_K_RESET;
            cfg_wait_reg <= 1'b0;
        end
        else
        begin
            cfg_wait_reg <= cfg_we;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HEIGHT: cfg_h_reg <= cfg_data;
                    CFG_WIDTH:  cfg_w_reg <= cfg_data;
                    CFG_KERNEL: cfg_k_reg <= cfg_data[CFG_K_W-1:0];
                    default:    ;
                endcase
            end
        end
    end

    // Clamp the registers into the supported range.
    assign h_eff = (cfg_h_reg == '0) ? H_W'(1) :
                   (int'(cfg_h_reg) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT) : H_W'(cfg_h_reg);
    assign w_eff = (cfg_w_reg == '0) ? W_W'(1) :
                   (int'(cfg_w_reg) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(cfg_w_reg);
    assign k_eff = (cfg_k_reg == '0) ? K_W'(1) :
                   (int'(cfg_k_reg) > MAX_KERNEL) ? K_W'(MAX_KERNEL) : K_W'(cfg_k_reg);
    assign pad_eff = k_eff >> 1;
    assign k_m1    = KC_W'(k_eff - K_W'(1));
    assign h_s     = $signed(CO_W'(h_eff));
    assign w_s     = $signed(CO_W'(w_eff));

    // Products of the sizes, registered; the input is held during a write and while cfg_wait_reg follows it.
    always_ff @(posedge clk)
    begin
        npix_reg <= PIX_CW'(h_eff) * PIX_CW'(w_eff);
        kk_reg   <= TAP_CW'(k_eff) * TAP_CW'(k_eff);
        padw_reg <= PW_W'(pad_eff) * PW_W'(w_eff);
    end

    // Tap walk helpers.
    assign in_image = (ih_reg >= 0) && (ih_reg < h_s) && (iw_reg >= 0) && (iw_reg < w_s);
    assign last_tap = (kw_reg == k_m1) && (kh_reg == k_m1);
    assign pa_start = $signed(PA_W'(drain_pos_reg)) - $signed(PA_W'(padw_reg))
                    - $signed(PA_W'(pad_eff));

    // One restoring-division step.
    assign div_shift = {rem_reg, div_q_reg[PIX_AW-1]};
    assign div_ge    = (div_shift >= (W_W + 1)'(w_eff));

    assign drain_wrap = (PIX_CW'(drain_pos_reg) >= npix_reg);
    assign drain_inc  = PIX_CW'(drain_pos_reg) + PIX_CW'(1);
    assign drain_last = (drain_inc == npix_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_mode == MODE_DRAIN))
                begin
                    state_next = (dirty_reg && !drain_wrap) ? ST_DIV : ST_SETUP;
                end
            end
            ST_DIV:
            begin
                if (div_cnt_reg == '0)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: state_next = ST_MAC;
            ST_MAC:
            begin
                if (last_tap)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (flush_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, store ports, MAC control.
    always_comb
    begin
        s_tready      = (state_reg == ST_IDLE) && !cfg_wait_reg && !cfg_we;
        tap_we        = 1'b0;
        pix_we        = 1'b0;
        pix_raddr     = '0;
        mac_ctl.load  = 1'b0;
        mac_ctl.issue = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                tap_we = accept && (in_mode == MODE_WEIGHT) && (tap_pos_reg < kk_reg);
                pix_we = accept && (in_mode == MODE_PIXEL) && (pix_pos_reg < npix_reg);
            end
            ST_SETUP: mac_ctl.load = 1'b1;
            ST_MAC:
            begin
                mac_ctl.issue = in_image;
                if (in_image)
                begin
                    pix_raddr = paddr_reg[PIX_AW-1:0];
                end
            end
            default: ;
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        dirty_next     = dirty_reg;
        bias_next      = bias_reg;
        tap_pos_next   = tap_pos_reg;
        pix_pos_next   = pix_pos_reg;
        drain_pos_next = drain_pos_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        div_q_next     = div_q_reg;
        rem_next       = rem_reg;
        div_cnt_next   = div_cnt_reg;
        kh_next        = kh_reg;
        kw_next        = kw_reg;
        taddr_next     = taddr_reg;
        ih_next        = ih_reg;
        iw_next        = iw_reg;
        iw0_next       = iw0_reg;
        paddr_next     = paddr_reg;
        rowbase_next   = rowbase_reg;
        flush_next     = flush_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        result_next    = result_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_mode)
                        MODE_WEIGHT:
                        begin
                            if (tap_pos_reg < kk_reg)
                            begin
                                tap_pos_next = tap_pos_reg + TAP_CW'(1);
                            end
                        end
                        MODE_BIAS:
                        begin
                            bias_next      = in_bias;
                            tap_pos_next   = '0;
                            pix_pos_next   = '0;
                            drain_pos_next = '0;
                            row_next       = '0;
                            col_next       = '0;
                            dirty_next     = 1'b0;
                        end
                        MODE_PIXEL:
                        begin
                            if (pix_pos_reg < npix_reg)
                            begin
                                pix_pos_next = pix_pos_reg + PIX_CW'(1);
                            end
                        end
                        MODE_DRAIN:
                        begin
                            // A position left past the end by a size change restarts.
                            if (drain_wrap)
                            begin
                                drain_pos_next = '0;
                                row_next       = '0;
                                col_next       = '0;
                                dirty_next     = 1'b0;
                            end
                            div_q_next   = drain_pos_reg;
                            rem_next     = '0;
                            div_cnt_next = DC_W'(PIX_AW - 1);
                        end
                        default: ;
                    endcase
                end
            end

            ST_DIV:
            begin
                // One quotient bit per cycle; quotient is the row, remainder the column.
                rem_next     = div_ge ? W_W'(div_shift - (W_W + 1)'(w_eff)) : W_W'(div_shift);
                div_q_next   = PIX_AW'({div_q_reg, div_ge});
                div_cnt_next = div_cnt_reg - DC_W'(1);
                if (div_cnt_reg == '0)
                begin
                    row_next   = ROW_W'(div_q_next);
                    col_next   = COL_W'(rem_next);
                    dirty_next = 1'b0;
                end
            end

            ST_SETUP:
            begin
                // Top-left tap of the window sits pad rows up and pad columns left.
                kh_next      = '0;
                kw_next      = '0;
                taddr_next   = '0;
                ih_next      = $signed(CO_W'(row_reg)) - $signed(CO_W'(pad_eff));
                iw_next      = $signed(CO_W'(col_reg)) - $signed(CO_W'(pad_eff));
                iw0_next     = $signed(CO_W'(col_reg)) - $signed(CO_W'(pad_eff));
                paddr_next   = pa_start;
                rowbase_next = pa_start;
                flush_next   = 1'b0;
            end

            ST_MAC:
            begin
                // Step through the taps in row-major order.
                taddr_next = taddr_reg + TAP_AW'(1);
                if (kw_reg == k_m1)
                begin
                    kw_next      = '0;
                    kh_next      = kh_reg + KC_W'(1);
                    ih_next      = ih_reg + CO_W'(1);
                    iw_next      = iw0_reg;
                    rowbase_next = rowbase_reg + $signed(PA_W'(w_eff));
                    paddr_next   = rowbase_reg + $signed(PA_W'(w_eff));
                end
                else
                begin
                    kw_next    = kw_reg + KC_W'(1);
                    iw_next    = iw_reg + CO_W'(1);
                    paddr_next = paddr_reg + PA_W'(1);
                end
            end

            ST_FLUSH: flush_next = 1'b1;

            ST_DONE:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    result_next   = acc;
                    out_row_next  = OUT_COORD_W'(row_reg);
                    out_col_next  = OUT_COORD_W'(col_reg);
                    out_last_next = drain_last;
                    // Advance the drain position in raster order.
                    if (drain_last)
                    begin
                        drain_pos_next = '0;
                        row_next       = '0;
                        col_next       = '0;
                    end
                    else
                    begin
                        drain_pos_next = PIX_AW'(drain_inc);
                        if ((W_W'(col_reg) + W_W'(1)) == w_eff)
                        begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end
                        else
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                end
            end

            default: ;
        endcase

        // Row and column must be rederived once the width may have changed.
        if (cfg_we)
        begin
            dirty_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dirty_reg     <= 1'b0;
            bias_reg      <= '0;
            tap_pos_reg   <= '0;
            pix_pos_reg   <= '0;
            drain_pos_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            div_cnt_reg   <= '0;
            kh_reg        <= '0;
            kw_reg        <= '0;
            taddr_reg     <= '0;
            flush_reg     <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dirty_reg     <= dirty_next;
            bias_reg      <= bias_next;
            tap_pos_reg   <= tap_pos_next;
            pix_pos_reg   <= pix_pos_next;
            drain_pos_reg <= drain_pos_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            div_cnt_reg   <= div_cnt_next;
            kh_reg        <= kh_next;
            kw_reg        <= kw_next;
            taddr_reg     <= taddr_next;
            flush_reg     <= flush_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        div_q_reg    <= div_q_next;
        rem_reg      <= rem_next;
        ih_reg       <= ih_next;
        iw_reg       <= iw_next;
        iw0_reg      <= iw0_next;
        paddr_reg    <= paddr_next;
        rowbase_reg  <= rowbase_next;
        result_reg   <= result_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_last_reg <= out_last_next;
    end

    // Tap and image stores.
    dwc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (TAP_DEPTH),
        .AW    (TAP_AW)
    ) u_tap_ram (
        .clk   (clk),
        .we    (tap_we),
        .waddr (TAP_AW'(tap_pos_reg)),
        .wdata (in_sample),
        .raddr (taddr_reg),
        .rdata (tap_rdata)
    );

    dwc_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (IMG_DEPTH),
        .AW    (PIX_AW)
    ) u_img_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (PIX_AW'(pix_pos_reg)),
        .wdata (in_sample),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    // Shared multiply-accumulate unit.
    dwc_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .bias  (bias_reg),
        .tap   (tap_rdata),
        .pix   (pix_rdata),
        .acc   (acc)
    );

    // Output stream.
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - ACC_W - 2 * OUT_COORD_W){1'b0}},
                       out_col_reg, out_row_reg, result_reg};
    assign m_tlast  = out_last_reg;

    // Checks on the sequencer.
    `DWC_ASSERT_IMP(a_busy_not_ready, clk, rst_n,
        state_reg != ST_IDLE, !s_tready, "input accepted while a drain is in progress")
    `DWC_ASSERT_IMP(a_tap_in_range, clk, rst_n,
        state_reg == ST_MAC, TAP_CW'(taddr_reg) < kk_reg, "tap read beyond the kernel")
    `DWC_ASSERT_IMP(a_drain_in_range, clk, rst_n,
        state_reg == ST_MAC, PIX_CW'(drain_pos_reg) < npix_reg, "drain position beyond the image")
    `DWC_ASSERT_IMP(a_rem_below_width, clk, rst_n,
        state_reg == ST_DIV, rem_reg < w_eff, "division remainder not below the width")
    `DWC_ASSERT_NEXT(a_done_delivers, clk, rst_n,
        (state_reg == ST_DONE) && out_free, m_tvalid && (state_reg == ST_IDLE),
        "finished result not presented")

endmodule
